// ===== src/frp_pkg.sv =====
package frp_pkg;

   localparam int OFFSET_W = 9;
   localparam int WDATA_W  = 32;
   localparam int RDATA_W  = 16;
   localparam int FIFO_W   = 32;
   localparam int PTR_W    = 32;

   // Access kinds.
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // Register offsets.
   localparam logic [OFFSET_W-1:0] OFS_FIFO_HI  = 9'h000;
   localparam logic [OFFSET_W-1:0] OFS_FIFO_LO  = 9'h001;
   localparam logic [OFFSET_W-1:0] OFS_STATUS   = 9'h11a;
   localparam logic [OFFSET_W-1:0] OFS_ID0      = 9'h11b;
   localparam logic [OFFSET_W-1:0] OFS_ID1      = 9'h11c;
   localparam logic [OFFSET_W-1:0] OFS_FIFO_CLR = 9'h11d;
   localparam logic [OFFSET_W-1:0] OFS_RAM_PTR  = 9'h11e;
   localparam logic [OFFSET_W-1:0] OFS_RAM_DATA = 9'h11f;

   // Fixed status words.
   localparam logic [RDATA_W-1:0] ID0_WORD = 16'h8002;
   localparam logic [RDATA_W-1:0] ID1_WORD = 16'h8000;

   // Pointer values at or above this select the high RAM bank.
   localparam logic [PTR_W-1:0] BANK_SELECT = 32'h0040_0000;

   // Status values that mark the block busy.
   localparam logic [WDATA_W-1:0] STATUS_BUSY_A = 32'd1;
   localparam logic [WDATA_W-1:0] STATUS_BUSY_B = 32'd2;

endpackage

// ===== src/frp_req_if.sv =====
interface frp_req_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [frp_pkg::OFFSET_W-1:0]  offset;
   logic [frp_pkg::WDATA_W-1:0]   wdata;
   logic                          no_side_effects;

   modport source (output valid, output kind, output offset, output wdata,
                   output no_side_effects, input ready);
   modport sink   (input valid, input kind, input offset, input wdata,
                   input no_side_effects, output ready);
endinterface

// ===== src/frp_rsp_if.sv =====
interface frp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [frp_pkg::RDATA_W-1:0]  rdata;
   logic                         flag_drive;
   logic                         flag_level;

   modport source (output valid, output rdata, output flag_drive, output flag_level,
                   input ready);
   modport sink   (input valid, input rdata, input flag_drive, input flag_level,
                   output ready);
endinterface

// ===== src/frp_ram.sv =====
module frp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/fifo_and_ram_port_registers.sv =====
// Bus register block with a command FIFO, a status class and a banked RAM window.
//
// Channels: req carries one bus access (kind, word offset, write data and a
// no-side-effects flag for debugger reads); rsp returns exactly one result per
// access: read data plus whether the access drives the handshake flag and at
// which level.
//
// The cycle of the transfer on req issues the memory reads (FIFO word and RAM
// bank word, registered in the RAMs), and the commit, once the output register
// is free, applies all state changes and loads the result register. A new
// access is taken again in the cycle after the commit, so the block does not
// take a new access before it is through with the last one.
//
// Reset clears the FIFO pointers, the status class and the RAM pointer; the
// FIFO and RAM contents are not cleared and no clearing pass is run.
// If rsp stalls, a finished result waits in the output register while the next
// access is still taken and read; that access holds its update until the
// output register is free.
module fifo_and_ram_port_registers #(
   parameter int FIFO_DEPTH     = 2048,
   parameter int BANK_ADDR_BITS = 22
) (
   input logic        clock,
   input logic        reset,
   frp_req_if.sink    req_bus,
   frp_rsp_if.source  rsp_bus
);

   localparam int FIFO_IDX_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_HALF  = FIFO_DEPTH / 2;
   localparam int BANK_DEPTH = 2 ** (BANK_ADDR_BITS + 1);
   localparam logic [FIFO_IDX_W-1:0] RD_LEVEL_MARK = FIFO_IDX_W'(FIFO_HALF - 1);
   localparam logic [FIFO_IDX_W-1:0] WR_LEVEL_MARK = FIFO_IDX_W'(FIFO_HALF);

   // Control state.
   logic                            busy_ff, busy_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [FIFO_IDX_W-1:0]           fifo_wr_ff, fifo_wr_in;
   logic [FIFO_IDX_W-1:0]           fifo_rd_ff, fifo_rd_in;
   logic                            status_busy_ff, status_busy_in;
   logic [frp_pkg::PTR_W-1:0]       ram_ptr_ff, ram_ptr_in;

   // Held access and result payload.
   logic                            kind_ff;
   logic [frp_pkg::OFFSET_W-1:0]    offset_ff;
   logic [frp_pkg::WDATA_W-1:0]     wdata_ff;
   logic                            quiet_ff;
   logic [frp_pkg::RDATA_W-1:0]     rdata_ff, rdata_in;
   logic                            flag_drive_ff, flag_drive_in;
   logic                            flag_level_ff, flag_level_in;

   logic                            req_take;
   logic                            commit;
   logic                            fifo_we;
   logic                            bank_we;
   logic [frp_pkg::FIFO_W-1:0]      fifo_rd_data;
   logic [frp_pkg::RDATA_W-1:0]     bank_rd_data;
   logic [BANK_ADDR_BITS:0]         bank_addr;

   assign req_bus.ready = !busy_ff;
   assign req_take      = req_bus.valid && !busy_ff;
   assign commit        = busy_ff && (!rsp_valid_ff || rsp_bus.ready);

   // The pointer cannot change between the read issue and the commit of one
   // access, so the same address serves both.
   assign bank_addr = {ram_ptr_ff >= frp_pkg::BANK_SELECT, ram_ptr_ff[BANK_ADDR_BITS-1:0]};

   frp_ram #(
      .WIDTH (frp_pkg::FIFO_W),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (fifo_wr_ff),
      .wr_data (wdata_ff),
      .rd_en   (req_take),
      .rd_addr (fifo_rd_ff),
      .rd_data (fifo_rd_data)
   );

   frp_ram #(
      .WIDTH (frp_pkg::RDATA_W),
      .DEPTH (BANK_DEPTH)
   ) u_bank_ram (
      .clock   (clock),
      .wr_en   (bank_we),
      .wr_addr (bank_addr),
      .wr_data (wdata_ff[frp_pkg::RDATA_W-1:0]),
      .rd_en   (req_take),
      .rd_addr (bank_addr),
      .rd_data (bank_rd_data)
   );

   always_comb begin
      busy_in        = busy_ff;
      fifo_wr_in     = fifo_wr_ff;
      fifo_rd_in     = fifo_rd_ff;
      status_busy_in = status_busy_ff;
      ram_ptr_in     = ram_ptr_ff;
      rdata_in       = '0;
      flag_drive_in  = 1'b0;
      flag_level_in  = 1'b0;
      fifo_we        = 1'b0;
      bank_we        = 1'b0;

      if (kind_ff == frp_pkg::KIND_READ) begin
         case (offset_ff)
            frp_pkg::OFS_FIFO_HI: begin
               rdata_in = fifo_rd_data[frp_pkg::FIFO_W-1:frp_pkg::RDATA_W];
            end
            frp_pkg::OFS_FIFO_LO: begin
               rdata_in = fifo_rd_data[frp_pkg::RDATA_W-1:0];
               if (!quiet_ff) begin
                  flag_drive_in = 1'b1;
                  flag_level_in = status_busy_ff || (fifo_rd_ff >= RD_LEVEL_MARK);
                  fifo_rd_in    = fifo_rd_ff + 1'b1;
               end
            end
            frp_pkg::OFS_ID0: begin
               rdata_in = frp_pkg::ID0_WORD;
            end
            frp_pkg::OFS_ID1: begin
               rdata_in = frp_pkg::ID1_WORD;
            end
            frp_pkg::OFS_RAM_DATA: begin
               rdata_in = bank_rd_data;
               if (!quiet_ff) begin
                  ram_ptr_in = ram_ptr_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end else begin
         case (offset_ff)
            frp_pkg::OFS_FIFO_HI: begin
               flag_drive_in = 1'b1;
               flag_level_in = status_busy_ff || (fifo_wr_ff < WR_LEVEL_MARK);
               fifo_we       = commit;
               fifo_wr_in    = fifo_wr_ff + 1'b1;
            end
            frp_pkg::OFS_STATUS: begin
               status_busy_in = (wdata_ff == frp_pkg::STATUS_BUSY_A) ||
                                (wdata_ff == frp_pkg::STATUS_BUSY_B);
               fifo_wr_in     = '0;
               fifo_rd_in     = '0;
            end
            frp_pkg::OFS_FIFO_CLR: begin
               fifo_wr_in = '0;
               fifo_rd_in = '0;
            end
            frp_pkg::OFS_RAM_PTR: begin
               ram_ptr_in = wdata_ff;
            end
            frp_pkg::OFS_RAM_DATA: begin
               bank_we    = commit;
               ram_ptr_in = ram_ptr_ff + 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (req_take) begin
         busy_in = 1'b1;
      end else if (commit) begin
         busy_in = 1'b0;
      end

      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         fifo_wr_ff     <= '0;
         fifo_rd_ff     <= '0;
         status_busy_ff <= 1'b0;
         ram_ptr_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            fifo_wr_ff     <= fifo_wr_in;
            fifo_rd_ff     <= fifo_rd_in;
            status_busy_ff <= status_busy_in;
            ram_ptr_ff     <= ram_ptr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff   <= req_bus.kind;
         offset_ff <= req_bus.offset;
         wdata_ff  <= req_bus.wdata;
         quiet_ff  <= req_bus.no_side_effects;
      end
      if (commit) begin
         rdata_ff      <= rdata_in;
         flag_drive_ff <= flag_drive_in;
         flag_level_ff <= flag_level_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.rdata      = rdata_ff;
   assign rsp_bus.flag_drive = flag_drive_ff;
   assign rsp_bus.flag_level = flag_level_ff;

endmodule

// ===== tb/sv/fifo_and_ram_port_registers_tb.sv =====
`timescale 1ns / 100ps

module fifo_and_ram_port_registers_tb;

   localparam int FIFO_DEPTH       = 2048;
   localparam int FIFO_HALF        = FIFO_DEPTH / 2;
   localparam int IDX_W            = $clog2(FIFO_DEPTH);
   localparam int BANK_BITS        = 22;
   localparam int RANDOM_PER_PHASE = 500;
   localparam int DRAIN_CYCLES     = 10;
   localparam int STALL_LIMIT      = 2000;
   localparam int HOLD_CYCLES      = 300;
   localparam int MAX_REPORTS      = 10;

   typedef struct packed {
      logic                         kind;
      logic [frp_pkg::OFFSET_W-1:0] offset;
      logic [frp_pkg::WDATA_W-1:0]  wdata;
      logic                         no_side_effects;
   } bus_access_type;

   typedef struct packed {
      logic [frp_pkg::RDATA_W-1:0] rdata;
      logic                        flag_drive;
      logic                        flag_level;
   } bus_result_type;

   typedef struct packed {
      bus_access_type acc;
      logic           known;
      bus_result_type res;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   frp_req_if req_bus();
   frp_rsp_if rsp_bus();

   fifo_and_ram_port_registers #(
      .FIFO_DEPTH     (FIFO_DEPTH),
      .BANK_ADDR_BITS (BANK_BITS)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the block state.
   logic [frp_pkg::FIFO_W-1:0] fifo_words [FIFO_DEPTH];
   bit                         fifo_word_set [FIFO_DEPTH];
   logic [IDX_W-1:0]           wr_idx = '0;
   logic [IDX_W-1:0]           rd_idx = '0;
   bit                         busy;
   logic [frp_pkg::PTR_W-1:0]  ram_ptr = '0;
   logic [15:0]                bank_words [logic [BANK_BITS:0]];
   logic [frp_pkg::PTR_W-1:0]  ram_marks [$];

   bus_result_type pending_results [$];

   int stim_phase;
   int send_idle_pct;
   int recv_idle_pct;
   int fail_count;
   int results_seen;
   int idle_cycles;
   int hold_left;
   bit hold_done;

   int n_accesses, n_fifo_writes, n_fifo_reads, n_ram, n_status;
   int n_flag_high, n_flag_low, wr_wraps, rd_wraps;

   // Rows with known set carry a result that is plain from the register map.
   directed_row_type directed_rows [26] = '{
      '{'{frp_pkg::KIND_READ,  frp_pkg::OFS_ID0,      32'h0000_0000, 1'b0}, 1'b1,
        '{frp_pkg::ID0_WORD, 1'b0, 1'b0}},
      '{'{frp_pkg::KIND_READ,  frp_pkg::OFS_ID1,      32'h0000_0000, 1'b1}, 1'b1,
        '{frp_pkg::ID1_WORD, 1'b0, 1'b0}},
      '{'{frp_pkg::KIND_READ,  9'h1ff,                32'hffff_ffff, 1'b0}, 1'b1,
        '{16'h0000, 1'b0, 1'b0}},
      '{'{frp_pkg::KIND_WRITE, frp_pkg::OFS_FIFO_HI,  32'hffff_ffff, 1'b0}, 1'b1,
        '{16'h0000, 1'b1, 1'b1}},
      '{'{frp_pkg::KIND_WRITE, frp_pkg::OFS_FIFO_HI,  32'h0000_0000, 1'b1}, 1'b1,
        '{16'h0000, 1'b1, 1'b1}},
      '{'{frp_pkg::KIND_READ,  frp_pkg::OFS_FIFO_HI,  32'h0000_0000, 1'b0}, 1'b1,
        '{16'hffff, 1'b0, 1'b0}},
      '{'{frp_pkg::KIND_READ,  frp_pkg::OFS_FIFO_LO,  32'h0000_0000, 1'b1}, 1'b1,
        '{16'hffff, 1'b0, 1'b0}},
      '{'{frp_pkg::KIND_READ,  frp_pkg::OFS_FIFO_LO,  32'h0000_0000, 1'b0}, 1'b1,
        '{16'hffff, 1'b1, 1'b0}},
      '{'{frp_pkg::KIND_READ,  frp_pkg::OFS_FIFO_HI,  32'h0000_0000, 1'b0}, 1'b1,
        '{16'h0000, 1'b0, 1'b0}},
      '{'{frp_pkg::KIND_WRITE, frp_pkg::OFS_STATUS,   frp_pkg::STATUS_BUSY_A, 1'b0}, 1'b1,
        '{16'h0000, 1'b0, 1'b0}},
      '{'{frp_pkg::KIND_READ,  frp_pkg::OFS_FIFO_LO,  32'h0000_0000, 1'b0}, 1'b1,
        '{16'hffff, 1'b1, 1'b1}},
      '{'{frp_pkg::KIND_WRITE, frp_pkg::OFS_FIFO_HI,  32'h1234_5678, 1'b0}, 1'b1,
        '{16'h0000, 1'b1, 1'b1}},
      '{'{frp_pkg::KIND_WRITE, frp_pkg::OFS_STATUS,   frp_pkg::STATUS_BUSY_B, 1'b0}, 1'b0,
        '{16'h0000, 1'b0, 1'b0}},
      '{'{frp_pkg::KIND_WRITE, frp_pkg::OFS_STATUS,   32'h0000_0003, 1'b0}, 1'b0,
        '{16'h0000, 1'b0, 1'b0}},
      '{'{frp_pkg::KIND_WRITE, frp_pkg::OFS_FIFO_CLR, 32'h0000_0000, 1'b1}, 1'b0,
        '{16'h0000, 1'b0, 1'b0}},
      '{'{frp_pkg::KIND_WRITE, frp_pkg::OFS_ID0,      32'h0000_aaaa, 1'b0}, 1'b1,
        '{16'h0000, 1'b0, 1'b0}},
      '{'{frp_pkg::KIND_WRITE, frp_pkg::OFS_RAM_PTR,  32'h003f_fffe, 1'b0}, 1'b0,
        '{16'h0000, 1'b0, 1'b0}},
      '{'{frp_pkg::KIND_WRITE, frp_pkg::OFS_RAM_DATA, 32'hffff_abcd, 1'b0}, 1'b0,
        '{16'h0000, 1'b0, 1'b0}},
      '{'{frp_pkg::KIND_WRITE, frp_pkg::OFS_RAM_DATA, 32'h0000_1234, 1'b0}, 1'b0,
        '{16'h0000, 1'b0, 1'b0}},
      '{'{frp_pkg::KIND_WRITE, frp_pkg::OFS_RAM_PTR,  32'hffff_ffff, 1'b0}, 1'b0,
        '{16'h0000, 1'b0, 1'b0}},
      '{'{frp_pkg::KIND_WRITE, frp_pkg::OFS_RAM_DATA, 32'h0000_5555, 1'b0}, 1'b0,
        '{16'h0000, 1'b0, 1'b0}},
      '{'{frp_pkg::KIND_WRITE, frp_pkg::OFS_RAM_PTR,  32'h003f_fffe, 1'b0}, 1'b0,
        '{16'h0000, 1'b0, 1'b0}},
      '{'{frp_pkg::KIND_READ,  frp_pkg::OFS_RAM_DATA, 32'h0000_0000, 1'b1}, 1'b1,
        '{16'habcd, 1'b0, 1'b0}},
      '{'{frp_pkg::KIND_READ,  frp_pkg::OFS_RAM_DATA, 32'h0000_0000, 1'b0}, 1'b0,
        '{16'h0000, 1'b0, 1'b0}},
      '{'{frp_pkg::KIND_READ,  frp_pkg::OFS_RAM_DATA, 32'h0000_0000, 1'b0}, 1'b0,
        '{16'h0000, 1'b0, 1'b0}},
      '{'{frp_pkg::KIND_READ,  frp_pkg::OFS_RAM_PTR,  32'h0000_0000, 1'b0}, 1'b1,
        '{16'h0000, 1'b0, 1'b0}}
   };

   // The top bit picks the bank, the rest is the masked word index.
   function automatic logic [BANK_BITS:0] bank_key(logic [frp_pkg::PTR_W-1:0] ptr);
      return {ptr >= frp_pkg::BANK_SELECT, ptr[BANK_BITS-1:0]};
   endfunction

   function automatic bus_result_type apply_bus_access(bus_access_type a);
      bus_result_type      r;
      logic [BANK_BITS:0]  key;
      r   = '0;
      key = bank_key(ram_ptr);
      n_accesses++;
      if (a.kind == frp_pkg::KIND_READ) begin
         case (a.offset)
            frp_pkg::OFS_FIFO_HI: begin
               r.rdata = fifo_words[rd_idx][31:16];
               n_fifo_reads++;
            end
            frp_pkg::OFS_FIFO_LO: begin
               r.rdata = fifo_words[rd_idx][15:0];
               n_fifo_reads++;
               if (!a.no_side_effects) begin
                  r.flag_drive = 1'b1;
                  r.flag_level = busy || (rd_idx >= FIFO_HALF - 1);
                  if (rd_idx == FIFO_DEPTH - 1) rd_wraps++;
                  rd_idx = rd_idx + 1'b1;
               end
            end
            frp_pkg::OFS_ID0: r.rdata = frp_pkg::ID0_WORD;
            frp_pkg::OFS_ID1: r.rdata = frp_pkg::ID1_WORD;
            frp_pkg::OFS_RAM_DATA: begin
               r.rdata = bank_words[key];
               n_ram++;
               if (!a.no_side_effects) ram_ptr = ram_ptr + 1'b1;
            end
            default: ;
         endcase
      end else begin
         case (a.offset)
            frp_pkg::OFS_FIFO_HI: begin
               r.flag_drive = 1'b1;
               r.flag_level = busy || (wr_idx < FIFO_HALF);
               fifo_words[wr_idx]    = a.wdata;
               fifo_word_set[wr_idx] = 1'b1;
               n_fifo_writes++;
               if (wr_idx == FIFO_DEPTH - 1) wr_wraps++;
               wr_idx = wr_idx + 1'b1;
            end
            frp_pkg::OFS_STATUS: begin
               busy   = (a.wdata == frp_pkg::STATUS_BUSY_A) ||
                        (a.wdata == frp_pkg::STATUS_BUSY_B);
               wr_idx = '0;
               rd_idx = '0;
               n_status++;
            end
            frp_pkg::OFS_FIFO_CLR: begin
               wr_idx = '0;
               rd_idx = '0;
               n_status++;
            end
            frp_pkg::OFS_RAM_PTR: begin
               ram_ptr = a.wdata;
               n_ram++;
            end
            frp_pkg::OFS_RAM_DATA: begin
               bank_words[key] = a.wdata[15:0];
               ram_ptr         = ram_ptr + 1'b1;
               n_ram++;
            end
            default: ;
         endcase
      end
      if (r.flag_drive) begin
         if (r.flag_level) n_flag_high++;
         else n_flag_low++;
      end
      return r;
   endfunction

   function automatic logic [frp_pkg::PTR_W-1:0] pick_ram_pointer();
      logic [frp_pkg::PTR_W-1:0] p;
      // Half of the loads return to an earlier spot so that written words are read back.
      if (ram_marks.size() != 0 && $urandom_range(1) == 0)
         return ram_marks[$urandom_range(ram_marks.size() - 1)];
      case ($urandom_range(3))
         0:       p = frp_pkg::BANK_SELECT - $urandom_range(1, 4);
         1:       p = 32'hffff_ffff - $urandom_range(0, 3);
         2:       p = $urandom_range(15);
         default: p = $urandom;
      endcase
      ram_marks.push_back(p);
      if (ram_marks.size() > 8) void'(ram_marks.pop_front());
      return p;
   endfunction

   // Reads of words never written are turned into writes. Clearing the FIFO is held
   // back until both pointers have wrapped, so the deep pointer range gets exercised.
   function automatic bus_access_type make_legal(bus_access_type a);
      if (a.kind == frp_pkg::KIND_READ) begin
         if ((a.offset == frp_pkg::OFS_FIFO_HI || a.offset == frp_pkg::OFS_FIFO_LO)
             && !fifo_word_set[rd_idx]) begin
            a.kind   = frp_pkg::KIND_WRITE;
            a.offset = frp_pkg::OFS_FIFO_HI;
         end else if (a.offset == frp_pkg::OFS_RAM_DATA
                      && !bank_words.exists(bank_key(ram_ptr))) begin
            a.kind = frp_pkg::KIND_WRITE;
         end
      end else if ((wr_wraps == 0 || rd_wraps == 0)
                   && (a.offset == frp_pkg::OFS_STATUS
                       || a.offset == frp_pkg::OFS_FIFO_CLR)) begin
         a.kind = frp_pkg::KIND_READ;
      end
      return a;
   endfunction

   function automatic bus_access_type pick_random_access();
      bus_access_type a;
      int             pick;
      a.kind            = frp_pkg::KIND_WRITE;
      a.offset          = frp_pkg::OFS_FIFO_HI;
      a.wdata           = $urandom;
      a.no_side_effects = ($urandom_range(1) == 1);
      pick              = $urandom_range(99);
      if (wr_wraps != 0 && rd_wraps != 0 && $urandom_range(99) < 4) begin
         a.offset = ($urandom_range(1) == 0) ? frp_pkg::OFS_FIFO_CLR : frp_pkg::OFS_STATUS;
         case ($urandom_range(4))
            0:       a.wdata = frp_pkg::STATUS_BUSY_A;
            1:       a.wdata = frp_pkg::STATUS_BUSY_B;
            2:       a.wdata = '0;
            3:       a.wdata = frp_pkg::STATUS_BUSY_B + 1;
            default: ;
         endcase
      end else if (pick < 40) begin
         a.offset = frp_pkg::OFS_FIFO_HI;
      end else if (pick < 90) begin
         a.kind            = frp_pkg::KIND_READ;
         a.offset          = ($urandom_range(99) < 85) ? frp_pkg::OFS_FIFO_LO
                                                       : frp_pkg::OFS_FIFO_HI;
         a.no_side_effects = ($urandom_range(9) == 0);
      end else if (pick < 96) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            a.offset = frp_pkg::OFS_RAM_PTR;
            a.wdata  = pick_ram_pointer();
         end else if (pick < 70) begin
            a.offset = frp_pkg::OFS_RAM_DATA;
         end else begin
            a.kind            = frp_pkg::KIND_READ;
            a.offset          = frp_pkg::OFS_RAM_DATA;
            a.no_side_effects = ($urandom_range(4) == 0);
         end
      end else if (pick < 98) begin
         a.kind = frp_pkg::KIND_READ;
         case ($urandom_range(5))
            0: begin
               a.offset = frp_pkg::OFS_ID0;
               a.kind   = ($urandom_range(1) == 0) ? frp_pkg::KIND_READ : frp_pkg::KIND_WRITE;
            end
            1: begin
               a.offset = frp_pkg::OFS_ID1;
               a.kind   = ($urandom_range(1) == 0) ? frp_pkg::KIND_READ : frp_pkg::KIND_WRITE;
            end
            2:       a.offset = frp_pkg::OFS_STATUS;
            3:       a.offset = frp_pkg::OFS_FIFO_CLR;
            4:       a.offset = frp_pkg::OFS_RAM_PTR;
            default: begin
               a.offset = frp_pkg::OFS_FIFO_LO;
               a.kind   = frp_pkg::KIND_WRITE;
            end
         endcase
      end else begin
         a.kind   = ($urandom_range(1) == 0) ? frp_pkg::KIND_READ : frp_pkg::KIND_WRITE;
         pick     = $urandom_range((1 << frp_pkg::OFFSET_W) - 1);
         a.offset = pick[frp_pkg::OFFSET_W-1:0];
      end
      return make_legal(a);
   endfunction

   // Offers one access and returns at the clock edge of its transfer.
   task automatic issue_access(bus_access_type a, logic known, bus_result_type typed);
      bus_result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.kind            <= a.kind;
      req_bus.offset          <= a.offset;
      req_bus.wdata           <= a.wdata;
      req_bus.no_side_effects <= a.no_side_effects;
      do @(posedge clock); while (!req_bus.ready);
      r = apply_bus_access(a);
      pending_results.push_back(known ? typed : r);
   endtask

   task automatic note_failure(string what, bus_result_type want, bus_result_type got);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("%t %s: expected rdata=%h drive=%b level=%b, got rdata=%h drive=%b level=%b",
                  $time, what, want.rdata, want.flag_drive, want.flag_level,
                  got.rdata, got.flag_drive, got.flag_level);
   endtask

   initial begin
      req_bus.valid           <= 1'b0;
      req_bus.kind            <= frp_pkg::KIND_READ;
      req_bus.offset          <= '0;
      req_bus.wdata           <= '0;
      req_bus.no_side_effects <= 1'b0;
      send_idle_pct = 32;
      recv_idle_pct = 53;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         issue_access(directed_rows[i].acc, directed_rows[i].known, directed_rows[i].res);

      for (stim_phase = 0; stim_phase < 3; stim_phase++) begin
         send_idle_pct = (stim_phase == 0) ? 32 : (stim_phase == 1) ? 53 : 0;
         recv_idle_pct = (stim_phase == 0) ? 53 : (stim_phase == 1) ? 32 : 0;
         repeat (RANDOM_PER_PHASE) issue_access(pick_random_access(), 1'b0, '0);
      end
      req_bus.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d accesses: %0d FIFO writes, %0d FIFO reads, %0d RAM window, %0d clears.",
               n_accesses, n_fifo_writes, n_fifo_reads, n_ram, n_status);
      $display("Flag driven high %0d and low %0d times; pointer wraps write %0d, read %0d; %0d errors.",
               n_flag_high, n_flag_low, wr_wraps, rd_wraps, fail_count);
      if (fail_count == 0) begin
         $display("fifo_and_ram_port_registers_tb passed");
      end else begin
         $display("fifo_and_ram_port_registers_tb failed");
      end
      $finish;
   end

   // Result side: random stalls, plus one long hold-off at the start of the last phase so
   // that the block backs up and stops taking requests.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (stim_phase == 2 && !hold_done) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= HOLD_CYCLES;
         hold_done     <= 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      bus_result_type got;
      bus_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.rdata, rsp_bus.flag_drive, rsp_bus.flag_level};
         results_seen++;
         if (pending_results.size() == 0) begin
            note_failure("result with no access pending", '0, got);
         end else begin
            want = pending_results.pop_front();
            if (got.rdata !== want.rdata || got.flag_drive !== want.flag_drive
                || got.flag_level !== want.flag_level)
               note_failure("result mismatch", want, got);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout after %0d cycles without a transfer, %0d results outstanding",
                  idle_cycles, pending_results.size());
         $display("fifo_and_ram_port_registers_tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ===== files.f =====
src/frp_pkg.sv
src/frp_req_if.sv
src/frp_rsp_if.sv
src/frp_ram.sv
src/fifo_and_ram_port_registers.sv
tb/sv/fifo_and_ram_port_registers_tb.sv
